// ===== rtl/fte_pkg.sv =====
// Shared types, codes and constants of the FAT entry engine.
package fte_pkg;

    // Default byte size of the table store
    localparam int TABLE_BYTES_DEF = 8192;

    // Width of a computed entry byte offset (16-bit cluster times two, plus headroom)
    localparam int OFF_W = 18;

    // Configuration port widths
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAT16_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 1'd1;

    // Action codes
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_GET   = 2'd1;
    localparam logic [1:0] ACT_SET   = 2'd2;
    localparam logic [1:0] ACT_ALLOC = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // End-of-chain marks and the 12-bit entry mask
    localparam logic [15:0] EOC_FAT12  = 16'h0FFF;
    localparam logic [15:0] EOC_FAT16  = 16'hFFFF;
    localparam logic [15:0] MASK_FAT12 = 16'h0FFF;

    // Request beat
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] cluster;
        logic [15:0] entry_value;
        logic [12:0] byte_address;
        logic [7:0]  byte_value;
    } fte_in_t;

    // Response beat
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] read_value;
        logic [15:0] found_cluster;
    } fte_out_t;

    // Controller states
    typedef enum logic [3:0] {
        FS_CLEAR,
        FS_IDLE,
        FS_EXEC,
        FS_ENT_CHK,
        FS_WR_LO,
        FS_WR_HI,
        FS_SCAN_RD,
        FS_SCAN_CHK,
        FS_DONE
    } fte_state_t;

    // Result selection for the result register
    typedef enum logic [2:0] {
        RES_NONE,
        RES_OK,
        RES_RANGE,
        RES_FULL,
        RES_READ,
        RES_FOUND
    } res_kind_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic      clr_step;
        logic      capture;
        logic      load_write;
        logic      issue_read;
        logic      scan_init;
        logic      scan_next;
        logic      claim;
        logic      wr_lo;
        logic      wr_hi;
        logic      push_out;
        res_kind_t res;
    } fte_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic       clear_last;
        logic [1:0] action;
        logic       load_ok;
        logic       clus_ok;
        logic       off_ok;
        logic       scan_end;
        logic       entry_zero;
        logic       out_free;
    } fte_stat_t;

endpackage

// ===== rtl/fte_mem.sv =====
// Byte store with one write port and two registered read ports.
module fte_mem
    import fte_pkg::*;
#(
    parameter int DEPTH = TABLE_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [7:0]    rdata_a,
    output logic [7:0]    rdata_b
);

    logic [7:0] mem_reg [0:DEPTH-1];
    logic [7:0] rd_a_reg;
    logic [7:0] rd_b_reg;

    // Write one byte, read two bytes and hold them until the next read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd_a_reg <= mem_reg[raddr_a];
            rd_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

// ===== rtl/fte_datapath.sv =====
// Datapath: config registers, item registers, entry packing, byte store and result stage.
module fte_datapath
    import fte_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  fte_in_t               req_data,
    input  fte_cmd_t              cmd,
    output fte_stat_t             stat,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output fte_out_t              rsp_data
);

    localparam int AW = $clog2(TABLE_BYTES);
    localparam logic [OFF_W-1:0] LAST_PAIR = OFF_W'(TABLE_BYTES - 2);
    localparam logic [OFF_W-1:0] TB_LIM    = OFF_W'(TABLE_BYTES);
    localparam logic [AW-1:0]    CLR_LAST  = AW'(TABLE_BYTES - 1);

    logic            mode_reg;
    logic [11:0]     count_reg;
    logic [AW-1:0]   clr_reg;
    logic [1:0]      act_reg;
    logic [15:0]     cur_reg;
    logic [15:0]     val_reg;
    logic [12:0]     baddr_reg;
    logic [7:0]      bval_reg;
    logic [1:0]      res_status_reg;
    logic [15:0]     res_read_reg;
    logic [15:0]     res_found_reg;
    logic            rsp_valid_reg;
    fte_out_t        rsp_data_reg;

    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] off_p1;
    logic [12:0]      lim;
    logic [15:0]      pair;
    logic [15:0]      entry;
    logic [15:0]      merged;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;
    logic [7:0]       rd_lo;
    logic [7:0]       rd_hi;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FAT16_MODE:    mode_reg  <= cfg_data[0];
                CFG_CLUSTER_COUNT: count_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Advance the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_reg <= clr_reg + AW'(1);
        end
    end

    // Hold the item and the running cluster
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg   <= req_data.action;
            cur_reg   <= req_data.cluster;
            val_reg   <= req_data.entry_value;
            baddr_reg <= req_data.byte_address;
            bval_reg  <= req_data.byte_value;
        end
        else if (cmd.scan_init)
        begin
            cur_reg <= 16'd2;
        end
        else if (cmd.scan_next)
        begin
            cur_reg <= cur_reg + 16'd1;
        end
        if (cmd.claim)
        begin
            val_reg <= mode_reg ? EOC_FAT16 : EOC_FAT12;
        end
    end

    // Locate the entry and check the cluster range
    always_comb
    begin
        if (mode_reg)
        begin
            off = {1'b0, cur_reg, 1'b0};
        end
        else
        begin
            off = OFF_W'(cur_reg) + OFF_W'(cur_reg[15:1]);
        end
        off_p1 = off + OFF_W'(1);
        lim    = {1'b0, count_reg} + 13'd2;
    end

    // Unpack the entry from the byte pair and merge a new value into it
    always_comb
    begin
        pair = {rd_hi, rd_lo};
        if (mode_reg)
        begin
            entry  = pair;
            merged = val_reg;
        end
        else if (cur_reg[0])
        begin
            entry  = {4'b0000, pair[15:4]};
            merged = {val_reg[11:0], pair[3:0]};
        end
        else
        begin
            entry  = pair & MASK_FAT12;
            merged = {pair[15:12], val_reg[11:0]};
        end
    end

    // Steer the single write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        if (cmd.clr_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
        end
        else if (cmd.load_write)
        begin
            mem_we    = 1'b1;
            mem_waddr = AW'(baddr_reg);
            mem_wdata = bval_reg;
        end
        else if (cmd.wr_lo)
        begin
            mem_we    = 1'b1;
            mem_waddr = off[AW-1:0];
            mem_wdata = merged[7:0];
        end
        else if (cmd.wr_hi)
        begin
            mem_we    = 1'b1;
            mem_waddr = off_p1[AW-1:0];
            mem_wdata = merged[15:8];
        end
    end

    fte_mem #(
        .DEPTH (TABLE_BYTES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (cmd.issue_read),
        .raddr_a (off[AW-1:0]),
        .raddr_b (off_p1[AW-1:0]),
        .rdata_a (rd_lo),
        .rdata_b (rd_hi)
    );

    // Record the result of the item
    always_ff @(posedge clk)
    begin
        case (cmd.res)
            RES_OK:
            begin
                res_status_reg <= STAT_OK;
                res_read_reg   <= '0;
                res_found_reg  <= '0;
            end
            RES_RANGE:
            begin
                res_status_reg <= STAT_RANGE;
                res_read_reg   <= '0;
                res_found_reg  <= '0;
            end
            RES_FULL:
            begin
                res_status_reg <= STAT_FULL;
                res_read_reg   <= '0;
                res_found_reg  <= '0;
            end
            RES_READ:
            begin
                res_status_reg <= STAT_OK;
                res_read_reg   <= entry;
                res_found_reg  <= '0;
            end
            RES_FOUND:
            begin
                res_status_reg <= STAT_OK;
                res_read_reg   <= '0;
                res_found_reg  <= cur_reg;
            end
            default: ;
        endcase
    end

    // Hold the response beat until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.push_out)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_out)
        begin
            rsp_data_reg.status        <= res_status_reg;
            rsp_data_reg.read_value    <= res_read_reg;
            rsp_data_reg.found_cluster <= res_found_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Report status to the controller
    always_comb
    begin
        stat.clear_last = (clr_reg == CLR_LAST);
        stat.action     = act_reg;
        stat.load_ok    = (OFF_W'(baddr_reg) < TB_LIM);
        stat.clus_ok    = (cur_reg >= 16'd2) && (cur_reg < {3'b000, lim});
        stat.off_ok     = (off <= LAST_PAIR);
        stat.scan_end   = (cur_reg >= {3'b000, lim});
        stat.entry_zero = (entry == 16'd0);
        stat.out_free   = !rsp_valid_reg || rsp_ready;
    end

endmodule

// ===== rtl/fte_ctrl.sv =====
// Controller: sequences clearing, loads, entry access and the allocation scan.
module fte_ctrl
    import fte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  fte_stat_t stat,
    output fte_cmd_t  cmd
);

    fte_state_t state_reg;
    fte_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FS_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = FS_IDLE;
                end
            end
            FS_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = FS_EXEC;
                end
            end
            FS_EXEC:
            begin
                case (stat.action)
                    ACT_LOAD:
                    begin
                        state_next = FS_DONE;
                    end
                    ACT_GET, ACT_SET:
                    begin
                        state_next = (stat.clus_ok && stat.off_ok) ? FS_ENT_CHK : FS_DONE;
                    end
                    default:
                    begin
                        state_next = FS_SCAN_RD;
                    end
                endcase
            end
            FS_ENT_CHK:
            begin
                state_next = (stat.action == ACT_GET) ? FS_DONE : FS_WR_LO;
            end
            FS_WR_LO:
            begin
                state_next = FS_WR_HI;
            end
            FS_WR_HI:
            begin
                state_next = FS_DONE;
            end
            FS_SCAN_RD:
            begin
                if (stat.scan_end || !stat.off_ok)
                begin
                    state_next = FS_DONE;
                end
                else
                begin
                    state_next = FS_SCAN_CHK;
                end
            end
            FS_SCAN_CHK:
            begin
                state_next = stat.entry_zero ? FS_WR_LO : FS_SCAN_RD;
            end
            FS_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd       = '0;
        cmd.res   = RES_NONE;
        req_ready = 1'b0;
        case (state_reg)
            FS_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            FS_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            FS_EXEC:
            begin
                case (stat.action)
                    ACT_LOAD:
                    begin
                        cmd.load_write = stat.load_ok;
                        cmd.res        = stat.load_ok ? RES_OK : RES_RANGE;
                    end
                    ACT_GET, ACT_SET:
                    begin
                        if (stat.clus_ok && stat.off_ok)
                        begin
                            cmd.issue_read = 1'b1;
                        end
                        else
                        begin
                            cmd.res = RES_RANGE;
                        end
                    end
                    default:
                    begin
                        cmd.scan_init = 1'b1;
                    end
                endcase
            end
            FS_ENT_CHK:
            begin
                if (stat.action == ACT_GET)
                begin
                    cmd.res = RES_READ;
                end
            end
            FS_WR_LO:
            begin
                cmd.wr_lo = 1'b1;
            end
            FS_WR_HI:
            begin
                cmd.wr_hi = 1'b1;
                cmd.res   = (stat.action == ACT_ALLOC) ? RES_FOUND : RES_OK;
            end
            FS_SCAN_RD:
            begin
                if (stat.scan_end)
                begin
                    cmd.res = RES_FULL;
                end
                else if (!stat.off_ok)
                begin
                    cmd.res = RES_RANGE;
                end
                else
                begin
                    cmd.issue_read = 1'b1;
                end
            end
            FS_SCAN_CHK:
            begin
                if (stat.entry_zero)
                begin
                    cmd.claim = 1'b1;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            FS_DONE:
            begin
                cmd.push_out = stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/fat_table_entry_engine.sv =====
// Top level of the FAT12/FAT16 allocation table engine.
//
// Channels: req (valid/ready, fte_in_t) carries one action per beat: load a raw
// table byte, get an entry, set an entry, or allocate the first free cluster.
// rsp (valid/ready, fte_out_t) returns one beat per request. cfg (valid/ready,
// always ready) writes fat16_mode (index 0) and cluster_count (index 1).
// Items are handled one at a time. After the accept in idle, the controller
// runs execute, then an entry check for get or set, a low and a high byte write
// for set, a read and a check per cluster for allocate, then for a free entry
// the low and high byte writes, and last done, which loads the response beat.
// A load or an out-of-range get or set goes from execute to done.
// The byte store has one write port, so a set writes its two bytes one after
// the other, and the scan reads and then checks one cluster at a time.
// Response valid is high from the next cycle, when the controller is back in
// idle and can take the next request. A finished beat waits in the output
// register while the next request is accepted; a stalled receiver holds the
// controller only when a second result is ready to go out.
// At reset the store is swept to zero, one byte a cycle, over all TABLE_BYTES
// bytes; req_ready stays low meanwhile, configuration writes are taken.
module fat_table_entry_engine
    import fte_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  fte_in_t               req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output fte_out_t              rsp_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    fte_cmd_t  cmd;
    fte_stat_t stat;

    assign cfg_ready = 1'b1;

    fte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fte_datapath #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_data  (req_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    // No request beat is taken while the clearing sweep runs
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !req_ready)
        else $error("request accepted during clearing sweep");

    // The high byte of an entry is written right after its low byte
    a_write_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_hi |-> $past(cmd.wr_lo))
        else $error("high byte written without preceding low byte");

    // A result is never pushed over a pending response beat
    a_push_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_out |-> (!rsp_valid || rsp_ready))
        else $error("response beat overwritten");

endmodule

// ===== sim/tb_fat_table_entry_engine.sv =====
// Self-checking testbench for the FAT12/FAT16 allocation table engine.
module tb_fat_table_entry_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import fte_pkg::*;

    // Idle cycles allowed with no beat on any channel: the reset sweep of the
    // store plus a full-table scan at the widest cluster count, with room to spare
    localparam int STALL_LIMIT      = 40000;
    localparam int RANDOM_PER_PHASE = 110;
    localparam int RANDOM_PHASES    = 5;
    localparam int DRAIN_CYCLES     = 16;

    // Row of the directed plan: either a register setting or one request beat
    typedef struct {
        bit                    is_setting;
        bit                    set_mode;
        logic [CFG_DATA_W-1:0] set_count;
        fte_in_t               op;
        bit                    known;
        fte_out_t              known_reply;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    fte_in_t               req_data = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    fte_out_t              rsp_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the table and of the registers
    bit [7:0]    fat_image [TABLE_BYTES_DEF];
    bit          fat16_sel = 1'b0;
    int unsigned count_sel = 0;

    fte_out_t    pending_replies [$];
    plan_row_t   directed_plan [$];
    bit          calm_mode = 1'b0;
    int          rsp_hold_left = 0;
    int          idle_cycles = 0;
    int          error_count = 0;
    int          requests_sent = 0;
    int          replies_checked = 0;
    int          settings_applied = 0;
    int          directed_count = 0;

    fat_table_entry_engine #(
        .TABLE_BYTES(TABLE_BYTES_DEF)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Byte offset of a cluster's entry; true when both entry bytes are in the store
    function automatic bit locate_entry(input int unsigned clus, output int unsigned off);
        off = fat16_sel ? clus * 2 : (clus * 3) / 2;
        return (off + 1) < TABLE_BYTES_DEF;
    endfunction

    function automatic logic [15:0] read_image_entry(input int unsigned clus,
                                                     input int unsigned off);
        logic [15:0] pair;
        pair = {fat_image[off + 1], fat_image[off]};
        if (fat16_sel)
            return pair;
        // Odd clusters sit in the upper 12 bits of the byte pair
        if ((clus & 1) != 0)
            return (pair >> 4) & MASK_FAT12;
        return pair & MASK_FAT12;
    endfunction

    function automatic void write_image_entry(input int unsigned clus, input int unsigned off,
                                              input logic [15:0] value);
        logic [15:0] pair;
        if (fat16_sel)
            pair = value;
        else
        begin
            // Keep the nibble that belongs to the neighbor cluster
            pair = {fat_image[off + 1], fat_image[off]};
            if ((clus & 1) != 0)
                pair = (pair & 16'h000F) | ((value & MASK_FAT12) << 4);
            else
                pair = (pair & 16'hF000) | (value & MASK_FAT12);
        end
        fat_image[off]     = pair[7:0];
        fat_image[off + 1] = pair[15:8];
    endfunction

    // Apply one action to the shadow table and return the reply it earns
    function automatic fte_out_t fat_table_apply(input fte_in_t op);
        fte_out_t    reply;
        int unsigned off;
        int unsigned clus;
        reply = '0;
        case (op.action)
            ACT_LOAD:
            begin
                if (op.byte_address < TABLE_BYTES_DEF)
                    fat_image[op.byte_address] = op.byte_value;
                else
                    reply.status = STAT_RANGE;
            end
            ACT_GET, ACT_SET:
            begin
                clus = 32'(op.cluster);
                if (clus < 2 || clus >= count_sel + 2 || !locate_entry(clus, off))
                    reply.status = STAT_RANGE;
                else if (op.action == ACT_GET)
                    reply.read_value = read_image_entry(clus, off);
                else
                    write_image_entry(clus, off, op.entry_value);
            end
            default:
            begin
                // First-fit scan from cluster 2; claim the first free entry
                reply.status = STAT_FULL;
                for (clus = 2; clus < count_sel + 2; clus++)
                begin
                    if (!locate_entry(clus, off))
                    begin
                        reply.status = STAT_RANGE;
                        break;
                    end
                    if (read_image_entry(clus, off) == 16'h0000)
                    begin
                        write_image_entry(clus, off, fat16_sel ? EOC_FAT16 : EOC_FAT12);
                        reply.found_cluster = clus[15:0];
                        reply.status = STAT_OK;
                        break;
                    end
                end
            end
        endcase
        return reply;
    endfunction

    function automatic fte_in_t make_op(input logic [1:0] action, input logic [15:0] clus,
                                        input logic [15:0] value, input logic [12:0] addr,
                                        input logic [7:0] bval);
        fte_in_t op;
        op.action       = action;
        op.cluster      = clus;
        op.entry_value  = value;
        op.byte_address = addr;
        op.byte_value   = bval;
        return op;
    endfunction

    function automatic fte_out_t make_reply(input logic [1:0] status, input logic [15:0] rd,
                                            input logic [15:0] found);
        fte_out_t reply;
        reply.status        = status;
        reply.read_value    = rd;
        reply.found_cluster = found;
        return reply;
    endfunction

    function automatic void plan_setting(input bit mode, input logic [CFG_DATA_W-1:0] count);
        plan_row_t row;
        row = '{default: '0};
        row.is_setting = 1'b1;
        row.set_mode   = mode;
        row.set_count  = count;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_op(input fte_in_t op, input bit known, input fte_out_t reply);
        plan_row_t row;
        row = '{default: '0};
        row.op          = op;
        row.known       = known;
        row.known_reply = reply;
        directed_plan.push_back(row);
    endfunction

    // Random request, mostly aimed at the live cluster range and its edges
    function automatic fte_in_t make_random_op();
        fte_in_t     op;
        int unsigned top_clus;
        int unsigned span;
        int unsigned roll;
        top_clus = count_sel + 1;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            op.action = ACT_LOAD;
        else if (roll < 45)
            op.action = ACT_GET;
        else if (roll < 70)
            op.action = ACT_SET;
        else
            op.action = ACT_ALLOC;

        roll = $urandom_range(0, 9);
        if (roll < 7 && count_sel != 0)
            op.cluster = 16'($urandom_range(2, top_clus));
        else if (roll < 9)
        begin
            case ($urandom_range(0, 3))
                0:       op.cluster = 16'd0;
                1:       op.cluster = 16'd1;
                2:       op.cluster = 16'(top_clus);
                default: op.cluster = 16'(top_clus + 1);
            endcase
        end
        else
            op.cluster = 16'($urandom_range(0, 65535));

        // Zero values free entries so that allocate keeps finding work
        if ($urandom_range(0, 2) == 0)
            op.entry_value = 16'h0000;
        else
            op.entry_value = 16'($urandom_range(0, 65535));

        span = fat16_sel ? top_clus * 2 + 1 : (top_clus * 3) / 2 + 1;
        if (span > TABLE_BYTES_DEF - 1)
            span = TABLE_BYTES_DEF - 1;
        if ($urandom_range(0, 1) == 0)
            op.byte_address = 13'($urandom_range(0, span));
        else
            op.byte_address = 13'($urandom_range(0, TABLE_BYTES_DEF - 1));

        if ($urandom_range(0, 3) == 0)
            op.byte_value = 8'h00;
        else
            op.byte_value = 8'($urandom_range(0, 255));
        return op;
    endfunction

    function automatic int idle_burst_len();
        if (calm_mode || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 19);
    endfunction

    // Send one request beat and record the reply it must earn
    task automatic push_request(input fte_in_t op, input bit known, input fte_out_t reply);
        int       gap;
        fte_out_t predicted;
        gap = idle_burst_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= op;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = fat_table_apply(op);
        pending_replies.push_back(known ? reply : predicted);
        requests_sent++;
    endtask

    // Write both registers once the block has drained
    task automatic apply_setting(input bit mode, input logic [CFG_DATA_W-1:0] count);
        logic [CFG_DATA_W-1:0] mode_word;
        mode_word    = '0;
        mode_word[0] = mode;
        req_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FAT16_MODE;
        cfg_data  <= mode_word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        fat16_sel = mode;
        cfg_index <= CFG_CLUSTER_COUNT;
        cfg_data  <= count;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        count_sel = 32'(count);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    initial
    begin
        foreach (fat_image[i])
            fat_image[i] = 8'h00;
    end

    // Stall the reply channel in random bursts, except in the calm stretch
    always @(posedge clk)
    begin
        if (rsp_hold_left > 0)
        begin
            rsp_hold_left = rsp_hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else if (!calm_mode && $urandom_range(0, 7) == 0)
        begin
            rsp_hold_left = $urandom_range(1, 19) - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    // Compare each reply beat with the oldest pending prediction
    always @(posedge clk)
    begin : reply_check
        fte_out_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: reply beat with none pending, expected nothing, actual %h",
                         $time, rsp_data);
                error_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                replies_checked++;
                if (rsp_data.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp_data.status);
                    error_count++;
                end
                if (rsp_data.read_value !== want.read_value)
                begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.read_value, rsp_data.read_value);
                    error_count++;
                end
                if (rsp_data.found_cluster !== want.found_cluster)
                begin
                    $display("%0t: found_cluster expected %h actual %h",
                             $time, want.found_cluster, rsp_data.found_cluster);
                    error_count++;
                end
            end
        end
    end

    // Abort when no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles, %0d replies pending",
                     $time, idle_cycles, pending_replies.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        bit                    ph_mode;
        logic [CFG_DATA_W-1:0] ph_count;
        fte_out_t              range_err;

        range_err = make_reply(STAT_RANGE, 16'h0000, 16'h0000);

        // Reset registers: 12-bit entries, no clusters
        plan_op(make_op(ACT_GET,   16'd2, 16'h0000, 13'd0, 8'h00), 1'b1, range_err);
        plan_op(make_op(ACT_ALLOC, 16'd0, 16'h0000, 13'd0, 8'h00), 1'b1,
                make_reply(STAT_FULL, 16'h0000, 16'h0000));
        plan_op(make_op(ACT_SET,   16'd2, 16'h0123, 13'd0, 8'h00), 1'b1, range_err);
        plan_op(make_op(ACT_LOAD,  16'd0, 16'h0000, 13'd0, 8'hFF), 1'b1,
                make_reply(STAT_OK, 16'h0000, 16'h0000));
        plan_op(make_op(ACT_LOAD,  16'd0, 16'h0000, 13'h1FFF, 8'hFF), 1'b1,
                make_reply(STAT_OK, 16'h0000, 16'h0000));

        // Three clusters: fill the table, free one, reclaim it
        plan_setting(1'b0, 12'd3);
        plan_op(make_op(ACT_ALLOC, 16'd0, 16'h0000, 13'd0, 8'h00), 1'b1,
                make_reply(STAT_OK, 16'h0000, 16'd2));
        plan_op(make_op(ACT_ALLOC, 16'd0, 16'h0000, 13'd0, 8'h00), 1'b1,
                make_reply(STAT_OK, 16'h0000, 16'd3));
        plan_op(make_op(ACT_ALLOC, 16'd0, 16'h0000, 13'd0, 8'h00), 1'b1,
                make_reply(STAT_OK, 16'h0000, 16'd4));
        plan_op(make_op(ACT_ALLOC, 16'd0, 16'h0000, 13'd0, 8'h00), 1'b1,
                make_reply(STAT_FULL, 16'h0000, 16'h0000));
        plan_op(make_op(ACT_GET,   16'd3, 16'h0000, 13'd0, 8'h00), 1'b1,
                make_reply(STAT_OK, EOC_FAT12, 16'h0000));
        plan_op(make_op(ACT_SET,   16'd3, 16'hFFFF, 13'd0, 8'h00), 1'b1,
                make_reply(STAT_OK, 16'h0000, 16'h0000));
        plan_op(make_op(ACT_GET,   16'd2, 16'h0000, 13'd0, 8'h00), 1'b0, range_err);
        plan_op(make_op(ACT_SET,   16'd2, 16'h0000, 13'd0, 8'h00), 1'b1,
                make_reply(STAT_OK, 16'h0000, 16'h0000));
        plan_op(make_op(ACT_ALLOC, 16'd0, 16'h0000, 13'd0, 8'h00), 1'b1,
                make_reply(STAT_OK, 16'h0000, 16'd2));
        plan_op(make_op(ACT_GET,   16'd1, 16'h0000, 13'd0, 8'h00), 1'b1, range_err);
        plan_op(make_op(ACT_GET,   16'd5, 16'h0000, 13'd0, 8'h00), 1'b1, range_err);

        // Widest table with 16-bit entries: last cluster ends at the last byte
        plan_setting(1'b1, 12'd4094);
        plan_op(make_op(ACT_SET,   16'd4095, 16'hFFFF, 13'd0, 8'h00), 1'b1,
                make_reply(STAT_OK, 16'h0000, 16'h0000));
        plan_op(make_op(ACT_GET,   16'd4095, 16'h0000, 13'd0, 8'h00), 1'b1,
                make_reply(STAT_OK, EOC_FAT16, 16'h0000));
        plan_op(make_op(ACT_GET,   16'd4096, 16'h0000, 13'd0, 8'h00), 1'b1, range_err);
        plan_op(make_op(ACT_SET,   16'hFFFF, 16'h0000, 13'd0, 8'h00), 1'b1, range_err);
        plan_op(make_op(ACT_GET,   16'd0, 16'h0000, 13'd0, 8'h00), 1'b1, range_err);
        plan_op(make_op(ACT_ALLOC, 16'd0, 16'h0000, 13'd0, 8'h00), 1'b0, range_err);
        plan_op(make_op(ACT_LOAD,  16'd0, 16'h0000, 13'h1555, 8'hAA), 1'b0, range_err);
        plan_op(make_op(ACT_SET,   16'd4095, 16'h0000, 13'd0, 8'h00), 1'b0, range_err);

        // Hold reset, then release it for good
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed plan
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_setting)
                apply_setting(directed_plan[i].set_mode, directed_plan[i].set_count);
            else
            begin
                push_request(directed_plan[i].op, directed_plan[i].known,
                             directed_plan[i].known_reply);
                directed_count++;
            end
        end

        // Random phases over wide and narrow tables in both entry widths
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    ph_mode  = 1'b0;
                    ph_count = 12'd4094;
                end
                1:
                begin
                    ph_mode  = 1'b1;
                    ph_count = 12'd4094;
                end
                2:
                begin
                    ph_mode  = 1'b0;
                    ph_count = 12'($urandom_range(1, 24));
                end
                3:
                begin
                    ph_mode  = 1'b1;
                    ph_count = 12'($urandom_range(1, 24));
                end
                default:
                begin
                    ph_mode  = 1'($urandom_range(0, 1));
                    ph_count = 12'($urandom_range(0, 4094));
                end
            endcase
            apply_setting(ph_mode, ph_count);
            // Drop all idling in the last phase
            calm_mode = (ph == RANDOM_PHASES - 1);
            repeat (RANDOM_PER_PHASE)
                push_request(make_random_op(), 1'b0, range_err);
        end

        // Drain the remaining replies, then give the block time to misbehave
        req_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests (%0d directed) across %0d register settings,",
                 requests_sent, directed_count, settings_applied);
        $display("with %0d reply beats checked and %0d mismatches.",
                 replies_checked, error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== fat_table_entry_engine.f =====
rtl/fte_pkg.sv
rtl/fte_mem.sv
rtl/fte_datapath.sv
rtl/fte_ctrl.sv
rtl/fat_table_entry_engine.sv
sim/tb_fat_table_entry_engine.sv
